// ===== sv/llh_pkg.sv =====
// shared types and constants of the log-linear latency histogram
// no dependencies; compile first
package llh_pkg;

  // fixed field widths
  localparam int OP_BITS  = 3;
  localparam int LAT_BITS = 64;

  // operation codes of an input word
  typedef enum logic [OP_BITS-1:0] {
    OP_RECORD = 3'd0,
    OP_COUNT  = 3'd1,
    OP_TOTAL  = 3'd2,
    OP_MIN    = 3'd3,
    OP_MAX    = 3'd4,
    OP_RANK   = 3'd5
  } op_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic clear_we;
    logic find_byte;
    logic find_len;
    logic find_idx;
    logic rec_read;
    logic rec_write;
    logic walk_read;
    logic load_out;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic addr_last;
    logic out_valid;
  } stat_t;

endpackage

// ===== sv/llh_if.sv =====
// valid/ready channels for input and result words of the histogram
// depends on llh_pkg for field widths
interface llh_in_if;
  logic                         valid;
  logic                         ready;
  logic [llh_pkg::OP_BITS-1:0]  operation;
  logic [llh_pkg::LAT_BITS-1:0] latency;
  logic [llh_pkg::LAT_BITS-1:0] rank;

  modport source (output valid, output operation, output latency, output rank, input ready);
  modport sink   (input valid, input operation, input latency, input rank, output ready);
endinterface

interface llh_out_if;
  logic                         valid;
  logic                         ready;
  logic [llh_pkg::LAT_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// ===== sv/llh_ctrl.sv =====
// controller of the histogram: clearing pass, record sequence, store walk
// depends on llh_pkg for command, status and operation codes
module llh_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic [llh_pkg::OP_BITS-1:0] in_op_i,
  output logic                        in_ready_o,
  input  llh_pkg::stat_t              status_i,
  output llh_pkg::cmd_t               cmd_o
);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REC_BYTE,
    ST_REC_LEN,
    ST_REC_IDX,
    ST_REC_READ,
    ST_REC_WRITE,
    ST_WALK,
    ST_DRAIN1,
    ST_DRAIN2,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_ready_o && in_valid_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:     if (status_i.addr_last) state_d = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          if (in_op_i == llh_pkg::OP_RECORD) begin
            state_d = ST_REC_BYTE;
          end else if (in_op_i == llh_pkg::OP_COUNT || in_op_i == llh_pkg::OP_TOTAL ||
                       in_op_i == llh_pkg::OP_MIN || in_op_i == llh_pkg::OP_MAX ||
                       in_op_i == llh_pkg::OP_RANK) begin
            state_d = ST_WALK;
          end
        end
      end
      ST_REC_BYTE:  state_d = ST_REC_LEN;
      ST_REC_LEN:   state_d = ST_REC_IDX;
      ST_REC_IDX:   state_d = ST_REC_READ;
      ST_REC_READ:  state_d = ST_REC_WRITE;
      ST_REC_WRITE: state_d = ST_IDLE;
      ST_WALK:      if (status_i.addr_last) state_d = ST_DRAIN1;
      ST_DRAIN1:    state_d = ST_DRAIN2;
      ST_DRAIN2:    state_d = ST_FINISH;
      ST_FINISH:    if (!status_i.out_valid) state_d = ST_IDLE;
      default:      state_d = ST_CLEAR;
    endcase
  end

  // command decode
  always_comb begin
    cmd_o           = '0;
    cmd_o.capture   = accept;
    cmd_o.clear_we  = (state_q == ST_CLEAR);
    cmd_o.find_byte = (state_q == ST_REC_BYTE);
    cmd_o.find_len  = (state_q == ST_REC_LEN);
    cmd_o.find_idx  = (state_q == ST_REC_IDX);
    cmd_o.rec_read  = (state_q == ST_REC_READ);
    cmd_o.rec_write = (state_q == ST_REC_WRITE);
    cmd_o.walk_read = (state_q == ST_WALK);
    cmd_o.load_out  = (state_q == ST_FINISH) && !status_i.out_valid;
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/llh_datapath.sv =====
// datapath of the histogram: count memory, bucket mapping, walk accumulators
// and result register; depends on llh_pkg
module llh_datapath #(
  parameter int MANTISSA_BITS = 4,
  parameter int EXPONENT_ROWS = 61,
  parameter int COUNT_BITS    = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  llh_pkg::cmd_t                cmd_i,
  output llh_pkg::stat_t               status_o,
  input  logic [llh_pkg::OP_BITS-1:0]  in_op_i,
  input  logic [llh_pkg::LAT_BITS-1:0] in_latency_i,
  input  logic [llh_pkg::LAT_BITS-1:0] in_rank_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [llh_pkg::LAT_BITS-1:0] out_value_o
);

  localparam int DEPTH = EXPONENT_ROWS * (1 << MANTISSA_BITS);
  localparam int EW    = $clog2(EXPONENT_ROWS);
  localparam int IW    = EW + MANTISSA_BITS;
  localparam int PW    = COUNT_BITS + MANTISSA_BITS + 1;
  localparam int VB    = llh_pkg::LAT_BITS;
  localparam int NB    = $clog2(VB + 1);
  localparam int SB    = $clog2(VB);

  localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};

  // captured word
  logic [llh_pkg::OP_BITS-1:0] op_q;
  logic [VB-1:0]               lat_q;
  logic [VB-1:0]               r_q;

  // record path registers
  logic [2:0]    hb_q;
  logic          nz_q;
  logic [NB-1:0] n_q;
  logic [IW-1:0] ridx_q;

  // memory and walk
  logic [COUNT_BITS-1:0] mem_q [DEPTH];
  logic [COUNT_BITS-1:0] rdata_q;
  logic [IW-1:0]         addr_q;
  logic [IW-1:0]         raddr;
  logic                  mem_we;
  logic [IW-1:0]         waddr;
  logic [COUNT_BITS-1:0] wdata;

  // walk pipeline
  logic          v1_q, v2_q;
  logic [IW-1:0] idx1_q;
  logic [VB-1:0] add_q;
  logic [EW-1:0] sh_q;
  logic [VB-1:0] acc_q;
  logic          found_q, any_q;
  logic [IW-1:0] hit_idx_q, max_idx_q;

  // result register
  logic          out_valid_q;
  logic [VB-1:0] out_value_q;

  // highest nonzero byte of the latency
  logic [7:0] byte_nz;
  logic [2:0] hb_d;
  always_comb begin
    hb_d = '0;
    for (int b = 0; b < 8; b++) begin
      byte_nz[b] = |lat_q[b*8 +: 8];
      if (byte_nz[b]) hb_d = 3'(b);
    end
  end

  // bit length from the highest byte
  logic [7:0]    sel_byte;
  logic [2:0]    pb_d;
  logic [NB-1:0] n_d;
  always_comb begin
    sel_byte = lat_q[{hb_q, 3'b000} +: 8];
    pb_d = '0;
    for (int k = 0; k < 8; k++) begin
      if (sel_byte[k]) pb_d = 3'(k);
    end
    n_d = nz_q ? NB'({hb_q, pb_d}) + NB'(1) : '0;
  end

  // exponent and mantissa, saturated into the top bucket
  logic [NB-1:0]            exp_w;
  logic [SB-1:0]            shamt;
  logic [VB-1:0]            shifted;
  logic [MANTISSA_BITS-1:0] mant_w;
  logic [IW-1:0]            idx_d;
  always_comb begin
    if (n_q > NB'(MANTISSA_BITS)) begin
      exp_w = n_q - NB'(MANTISSA_BITS);
      shamt = SB'(exp_w - NB'(1));
    end else begin
      exp_w = '0;
      shamt = '0;
    end
    shifted = lat_q >> shamt;
    mant_w  = shifted[MANTISSA_BITS-1:0];
    if (exp_w >= NB'(EXPONENT_ROWS)) begin
      idx_d = IW'(DEPTH - 1);
    end else begin
      idx_d = {exp_w[EW-1:0], mant_w};
    end
  end

  // memory port selection
  assign raddr  = cmd_i.rec_read ? ridx_q : addr_q;
  assign mem_we = cmd_i.clear_we || cmd_i.rec_write;
  assign waddr  = cmd_i.clear_we ? addr_q : ridx_q;
  assign wdata  = cmd_i.clear_we ? '0 :
                  (rdata_q == CountMax) ? rdata_q : rdata_q + COUNT_BITS'(1);

  // count memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  // per-bucket terms at the first walk stage
  logic [EW-1:0]            e1;
  logic [MANTISSA_BITS-1:0] m1;
  logic [EW-1:0]            sh1;
  logic [MANTISSA_BITS:0]   mult1;
  logic [PW-1:0]            prod1;
  logic                     hit1;
  always_comb begin
    e1    = idx1_q[IW-1:MANTISSA_BITS];
    m1    = idx1_q[MANTISSA_BITS-1:0];
    sh1   = (e1 == '0) ? '0 : e1 - EW'(1);
    mult1 = (e1 == '0) ? {1'b0, m1} : {1'b1, m1};
    prod1 = rdata_q * mult1;
    hit1  = (op_q == llh_pkg::OP_RANK) ? (r_q < VB'(rdata_q)) : (rdata_q != '0);
  end

  // selected bucket and its value for the result
  logic [IW-1:0]            sel_idx;
  logic                     sel_ok;
  logic [EW-1:0]            se;
  logic [MANTISSA_BITS-1:0] sm;
  logic [VB-1:0]            bval;
  logic [VB-1:0]            result;
  always_comb begin
    unique case (op_q)
      llh_pkg::OP_MIN: begin
        sel_idx = hit_idx_q;
        sel_ok  = found_q;
      end
      llh_pkg::OP_MAX: begin
        sel_idx = max_idx_q;
        sel_ok  = any_q;
      end
      llh_pkg::OP_RANK: begin
        sel_idx = found_q ? hit_idx_q : max_idx_q;
        sel_ok  = any_q;
      end
      default: begin
        sel_idx = max_idx_q;
        sel_ok  = 1'b0;
      end
    endcase
    se   = sel_idx[IW-1:MANTISSA_BITS];
    sm   = sel_idx[MANTISSA_BITS-1:0];
    bval = (se == '0) ? VB'(sm) : VB'({1'b1, sm}) << (se - EW'(1));
    if (op_q == llh_pkg::OP_COUNT || op_q == llh_pkg::OP_TOTAL) begin
      result = acc_q;
    end else begin
      result = sel_ok ? bval : '0;
    end
  end

  // control registers: address counter, walk valids, result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q      <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear_we || cmd_i.walk_read) begin
        addr_q <= (addr_q == IW'(DEPTH - 1)) ? '0 : addr_q + IW'(1);
      end
      v1_q <= cmd_i.walk_read;
      v2_q <= v1_q;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= in_op_i;
      lat_q   <= in_latency_i;
      r_q     <= in_rank_i;
      acc_q   <= '0;
      found_q <= 1'b0;
      any_q   <= 1'b0;
    end else begin
      // first walk stage: hits, rank countdown, addend
      if (v1_q) begin
        if (!found_q && hit1) begin
          found_q   <= 1'b1;
          hit_idx_q <= idx1_q;
        end
        if (!found_q && !hit1 && op_q == llh_pkg::OP_RANK) begin
          r_q <= r_q - VB'(rdata_q);
        end
        if (rdata_q != '0) begin
          any_q     <= 1'b1;
          max_idx_q <= idx1_q;
        end
      end
      // second walk stage: accumulate
      if (v2_q) begin
        acc_q <= acc_q + (add_q << sh_q);
      end
    end
    if (cmd_i.find_byte) begin
      hb_q <= hb_d;
      nz_q <= |byte_nz;
    end
    if (cmd_i.find_len) begin
      n_q <= n_d;
    end
    if (cmd_i.find_idx) begin
      ridx_q <= idx_d;
    end
    idx1_q <= addr_q;
    add_q  <= (op_q == llh_pkg::OP_TOTAL) ? VB'(prod1) : VB'(rdata_q);
    sh_q   <= (op_q == llh_pkg::OP_TOTAL) ? sh1 : '0;
    if (cmd_i.load_out) begin
      out_value_q <= result;
    end
  end

  assign status_o.addr_last = (addr_q == IW'(DEPTH - 1));
  assign status_o.out_valid = out_valid_q;
  assign out_valid_o        = out_valid_q;
  assign out_value_o        = out_value_q;

endmodule

// ===== sv/log_linear_latency_histogram.sv =====
// Log-linear latency histogram, top level: controller plus datapath.
// Record: after the accepting edge, byte search, bit length, bucket index,
//   memory read and write back run in turn before ready returns; a new record
//   is not taken while one is in progress.
// Query: a walk of the count memory, one bucket a cycle, through two pipeline
//   stages, then the result load; the next word is taken only after the load,
//   which waits while an earlier result word is still at the output.
// Reset: a clearing pass over all EXPONENT_ROWS * 2^MANTISSA_BITS buckets (976
//   at default) zeroes the store, with ready low meanwhile.
module log_linear_latency_histogram #(
  parameter int MANTISSA_BITS = 4,
  parameter int EXPONENT_ROWS = 61,
  parameter int COUNT_BITS    = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  llh_in_if.sink     in_i,
  llh_out_if.source  out_o
);

  llh_pkg::cmd_t  cmd;
  llh_pkg::stat_t status;

  // sequencing
  llh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_op_i    (in_i.operation),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // storage and arithmetic
  llh_datapath #(
    .MANTISSA_BITS (MANTISSA_BITS),
    .EXPONENT_ROWS (EXPONENT_ROWS),
    .COUNT_BITS    (COUNT_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .in_op_i      (in_i.operation),
    .in_latency_i (in_i.latency),
    .in_rank_i    (in_i.rank),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .out_value_o  (out_o.value)
  );

endmodule

// ===== sv/llh_checker.sv =====
// port-level checks of the histogram, bound to the top level
// depends on llh_pkg and log_linear_latency_histogram
module llh_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic [llh_pkg::OP_BITS-1:0]  in_op_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [llh_pkg::LAT_BITS-1:0] out_value_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // a record with no pending result never makes one
  a_record_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_op_i == llh_pkg::OP_RECORD && !out_valid_i |=> !out_valid_i)
    else $error("record produced a result word");

  // a valid operation keeps the input stalled while it is worked on
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_op_i <= llh_pkg::OP_RANK) |=> !in_ready_i)
    else $error("input ready right after an operation was taken");

  // a result only appears after the input has been stalled
  a_result_from_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result word appeared while input was open");

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_value_i))
    else $error("result word dropped or changed while stalled");

endmodule

bind log_linear_latency_histogram llh_checker u_llh_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_op_i     (in_i.operation),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_value_i (out_o.value)
);
